// ----- hw/rtl/iate_pkg.sv -----
// Package: shared types, command and status codes, sequencer states for the table engine.
package iate_pkg;

  localparam int DEPTH_DEF = 256;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int RES_W = 40;

  localparam logic [3:0] K_APPEND  = 4'd0;
  localparam logic [3:0] K_INSERT  = 4'd1;
  localparam logic [3:0] K_DELETE  = 4'd2;
  localparam logic [3:0] K_LSEARCH = 4'd3;
  localparam logic [3:0] K_BSEARCH = 4'd4;
  localparam logic [3:0] K_MIN     = 4'd5;
  localparam logic [3:0] K_MAX     = 4'd6;
  localparam logic [3:0] K_SUM     = 4'd7;
  localparam logic [3:0] K_SORT    = 4'd8;
  localparam logic [3:0] K_REVERSE = 4'd9;
  localparam logic [3:0] K_SORTED  = 4'd10;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_RANGE   = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [3:0]         kind;
    logic [7:0]         position;
    logic signed [31:0] operand_value;
  } cmd_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [7:0]         found_index;
    logic signed [39:0] result_value;
    logic               sorted_flag;
    logic [8:0]         length;
  } rsp_word_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_APPEND,
    S_SHUP_RD,
    S_SHUP_WR,
    S_PUT,
    S_SCAN_RD,
    S_SCAN_EV,
    S_SHDN_RD,
    S_SHDN_WR,
    S_SORT_RDK,
    S_SORT_KV,
    S_SORT_RDJ,
    S_SORT_EVJ,
    S_BS_RD,
    S_BS_EV,
    S_REV_RDA,
    S_REV_RDB,
    S_REV_WRA,
    S_REV_WRB,
    S_DONE
  } seq_state_t;

endpackage

// ----- hw/rtl/iate_mem.sv -----
// Table storage: one write port, one read port with registered read data.
module iate_mem import iate_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic signed [DATA_WIDTH-1:0] wdata,
  input  logic [AW-1:0]                raddr,
  output logic signed [DATA_WIDTH-1:0] rdata
);

  logic signed [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/integer_array_table_engine.sv -----
// Top level: command sequencer with one shared compare unit over the table memory.
//
//  channel | signals                  | direction | word
//  cmd     | cmd, cmd_valid, cmd_stall | in        | kind, position, operand_value
//  rsp     | rsp, rsp_valid, rsp_stall | out       | status, found_index, result_value,
//          |                          |           | sorted_flag, length
//
// Scans (search, min, max, sum, is-sorted, delete) visit the entries in order,
// reverse swaps pairs from both ends, sort is insertion sort, and binary search
// sorts the table first and then probes it. All paced by the single memory read port.
// Reset clears the length and the sequencer; table contents are not cleared.
// cmd_stall is high while a command is in work; the finished word sits in the
// rsp register, and the next command may be taken while it waits.
module integer_array_table_engine import iate_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  cmd_word_t cmd,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  output rsp_word_t rsp,
  output logic      rsp_valid,
  input  logic      rsp_stall
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = AW + 1;
  localparam int PW = (CW > 8) ? CW : 8;
  localparam logic signed [RES_W-1:0] TOPV =
    (RES_W'(1) <<< (DATA_WIDTH - 1)) - RES_W'(1);

  seq_state_t state, state_next;

  logic [CW-1:0] cnt, cnt_next;
  logic [3:0] kind, kind_next;
  logic [PW-1:0] posw, posw_next;
  logic signed [DATA_WIDTH-1:0] val, val_next;
  logic signed [DATA_WIDTH-1:0] tmp, tmp_next;
  logic [CW-1:0] i, i_next, j, j_next;
  logic signed [CW:0] lo, lo_next, hi, hi_next;
  logic signed [RES_W-1:0] acc, acc_next;
  logic [1:0] status, status_next;
  logic [CW-1:0] found, found_next;
  logic flag, flag_next;
  rsp_word_t rsp_next;
  logic rsp_valid_next;

  // memory port
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic signed [DATA_WIDTH-1:0] wdata, rdata;

  // shared compare unit
  logic signed [RES_W-1:0] cmp_a, cmp_b;
  logic lt, eq;
  logic signed [RES_W-1:0] rd_ext;

  logic take_cmd, rsp_free;
  logic signed [CW+1:0] mid_sum;
  logic [CW-1:0] mid;

  iate_mem #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign cmd_stall = (state != S_IDLE);
  assign take_cmd = cmd_valid && (state == S_IDLE);
  assign rsp_free = !rsp_valid || !rsp_stall;
  assign rd_ext = RES_W'(rdata);
  assign mid_sum = (CW + 2)'(lo) + (CW + 2)'(hi);
  assign mid = mid_sum[CW:1];

  // Feed the comparator from the operation in work.
  always_comb begin
    cmp_a = rd_ext;
    cmp_b = RES_W'(val);
    case (state)
      S_SCAN_EV: begin
        if (kind == K_MIN) begin
          cmp_a = rd_ext;
          cmp_b = acc;
        end else if (kind == K_MAX) begin
          cmp_a = acc;
          cmp_b = rd_ext;
        end else if (kind == K_SORTED) begin
          cmp_a = rd_ext;
          cmp_b = RES_W'(tmp);
        end
      end
      S_SORT_EVJ: begin
        cmp_a = RES_W'(tmp);
        cmp_b = rd_ext;
      end
      default: begin
        cmp_a = rd_ext;
        cmp_b = RES_W'(val);
      end
    endcase
  end

  assign lt = cmp_a < cmp_b;
  assign eq = cmp_a == cmp_b;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind)
            K_APPEND:  state_next = (cnt == CW'(DEPTH)) ? S_DONE : S_APPEND;
            K_INSERT: begin
              if (PW'(cmd.position) >= PW'(cnt) || cnt == CW'(DEPTH)) begin
                state_next = S_DONE;
              end else begin
                state_next = S_SHUP_RD;
              end
            end
            K_DELETE, K_LSEARCH, K_MIN, K_MAX, K_SUM, K_SORTED: state_next = S_SCAN_RD;
            K_BSEARCH, K_SORT: state_next = S_SORT_RDK;
            K_REVERSE: state_next = (cnt < CW'(2)) ? S_DONE : S_REV_RDA;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_APPEND:  state_next = S_DONE;
      S_SHUP_RD: state_next = S_SHUP_WR;
      S_SHUP_WR: state_next = (PW'(i - CW'(1)) > posw) ? S_SHUP_RD : S_PUT;
      S_PUT:     state_next = S_DONE;
      S_SCAN_RD: state_next = (i == cnt) ? S_DONE : S_SCAN_EV;
      S_SCAN_EV: begin
        state_next = S_SCAN_RD;
        if ((kind == K_DELETE || kind == K_LSEARCH) && eq) begin
          state_next = (kind == K_DELETE) ? S_SHDN_RD : S_DONE;
        end else if (kind == K_SORTED && i != '0 && lt) begin
          state_next = S_DONE;
        end
      end
      S_SHDN_RD: state_next = (i + CW'(1) >= cnt) ? S_DONE : S_SHDN_WR;
      S_SHDN_WR: state_next = S_SHDN_RD;
      S_SORT_RDK: begin
        if (i >= cnt) begin
          state_next = (kind == K_BSEARCH) ? S_BS_RD : S_DONE;
        end else begin
          state_next = S_SORT_KV;
        end
      end
      S_SORT_KV:  state_next = S_SORT_RDJ;
      S_SORT_RDJ: state_next = (j == '0) ? S_SORT_RDK : S_SORT_EVJ;
      S_SORT_EVJ: state_next = lt ? S_SORT_RDJ : S_SORT_RDK;
      S_BS_RD:    state_next = (lo > hi) ? S_DONE : S_BS_EV;
      S_BS_EV:    state_next = eq ? S_DONE : S_BS_RD;
      S_REV_RDA:  state_next = (i >= j) ? S_DONE : S_REV_RDB;
      S_REV_RDB:  state_next = S_REV_WRA;
      S_REV_WRA:  state_next = S_REV_WRB;
      S_REV_WRB:  state_next = S_REV_RDA;
      S_DONE:     state_next = rsp_free ? S_IDLE : S_DONE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Datapath and memory port control.
  always_comb begin
    cnt_next = cnt;
    kind_next = kind;
    posw_next = posw;
    val_next = val;
    tmp_next = tmp;
    i_next = i;
    j_next = j;
    lo_next = lo;
    hi_next = hi;
    acc_next = acc;
    status_next = status;
    found_next = found;
    flag_next = flag;
    rsp_next = rsp;
    rsp_valid_next = rsp_valid && rsp_stall;
    we = 1'b0;
    waddr = i[AW-1:0];
    wdata = rdata;
    raddr = i[AW-1:0];
    case (state)
      S_IDLE: begin
        if (take_cmd) begin
          kind_next = cmd.kind;
          posw_next = PW'(cmd.position);
          val_next = cmd.operand_value[DATA_WIDTH-1:0];
          status_next = ST_OK;
          found_next = '0;
          flag_next = 1'b0;
          acc_next = '0;
          i_next = '0;
          case (cmd.kind)
            K_APPEND: begin
              if (cnt == CW'(DEPTH)) status_next = ST_FULL;
            end
            K_INSERT: begin
              if (PW'(cmd.position) >= PW'(cnt)) begin
                status_next = ST_RANGE;
              end else if (cnt == CW'(DEPTH)) begin
                status_next = ST_FULL;
              end
              i_next = cnt;
            end
            K_MIN: acc_next = TOPV;
            K_MAX: acc_next = -TOPV;
            K_BSEARCH, K_SORT: i_next = CW'(1);
            K_REVERSE: j_next = cnt - CW'(1);
            default: begin
              i_next = '0;
            end
          endcase
        end
      end
      S_APPEND: begin
        we = 1'b1;
        waddr = cnt[AW-1:0];
        wdata = val;
        cnt_next = cnt + CW'(1);
      end
      S_SHUP_RD: raddr = AW'(i - CW'(1));
      S_SHUP_WR: begin
        we = 1'b1;
        waddr = i[AW-1:0];
        wdata = rdata;
        i_next = i - CW'(1);
      end
      S_PUT: begin
        we = 1'b1;
        waddr = posw[AW-1:0];
        wdata = val;
        cnt_next = cnt + CW'(1);
      end
      S_SCAN_RD: begin
        raddr = i[AW-1:0];
        if (i == cnt) begin
          if (kind == K_DELETE || kind == K_LSEARCH) status_next = ST_MISSING;
          if (kind == K_SORTED) flag_next = 1'b1;
        end
      end
      S_SCAN_EV: begin
        i_next = i + CW'(1);
        case (kind)
          K_DELETE, K_LSEARCH: begin
            if (eq) begin
              found_next = i;
              i_next = i;
            end
          end
          K_MIN, K_MAX: begin
            if (lt) acc_next = rd_ext;
          end
          K_SUM: acc_next = acc + rd_ext;
          K_SORTED: tmp_next = rdata;
          default: begin
            acc_next = acc;
          end
        endcase
      end
      S_SHDN_RD: begin
        raddr = AW'(i + CW'(1));
        if (i + CW'(1) >= cnt) cnt_next = cnt - CW'(1);
      end
      S_SHDN_WR: begin
        we = 1'b1;
        waddr = i[AW-1:0];
        wdata = rdata;
        i_next = i + CW'(1);
      end
      S_SORT_RDK: begin
        raddr = i[AW-1:0];
        lo_next = '0;
        hi_next = $signed({1'b0, cnt}) - (CW + 1)'(1);
      end
      S_SORT_KV: begin
        tmp_next = rdata;
        j_next = i;
      end
      S_SORT_RDJ: begin
        raddr = AW'(j - CW'(1));
        if (j == '0) begin
          we = 1'b1;
          waddr = j[AW-1:0];
          wdata = tmp;
          i_next = i + CW'(1);
        end
      end
      S_SORT_EVJ: begin
        we = 1'b1;
        waddr = j[AW-1:0];
        if (lt) begin
          wdata = rdata;
          j_next = j - CW'(1);
        end else begin
          wdata = tmp;
          i_next = i + CW'(1);
        end
      end
      S_BS_RD: begin
        raddr = mid[AW-1:0];
        j_next = mid;
        if (lo > hi) status_next = ST_MISSING;
      end
      S_BS_EV: begin
        if (eq) begin
          found_next = j;
        end else if (lt) begin
          lo_next = $signed({1'b0, j}) + (CW + 1)'(1);
        end else begin
          hi_next = $signed({1'b0, j}) - (CW + 1)'(1);
        end
      end
      S_REV_RDA: raddr = i[AW-1:0];
      S_REV_RDB: begin
        raddr = j[AW-1:0];
        tmp_next = rdata;
      end
      S_REV_WRA: begin
        we = 1'b1;
        waddr = i[AW-1:0];
        wdata = rdata;
      end
      S_REV_WRB: begin
        we = 1'b1;
        waddr = j[AW-1:0];
        wdata = tmp;
        i_next = i + CW'(1);
        j_next = j - CW'(1);
      end
      S_DONE: begin
        if (rsp_free) begin
          rsp_valid_next = 1'b1;
          rsp_next.status = status;
          rsp_next.found_index = 8'(found);
          rsp_next.result_value =
            (kind == K_MIN || kind == K_MAX || kind == K_SUM) ? acc : '0;
          rsp_next.sorted_flag = flag;
          rsp_next.length = 9'(cnt);
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    kind <= kind_next;
    posw <= posw_next;
    val <= val_next;
    tmp <= tmp_next;
    i <= i_next;
    j <= j_next;
    lo <= lo_next;
    hi <= hi_next;
    acc <= acc_next;
    status <= status_next;
    found <= found_next;
    flag <= flag_next;
    rsp <= rsp_next;
  end

endmodule

// ----- verif/integer_array_table_engine_tb.sv -----
// Testbench for the table engine: directed table of commands, then random traffic, self-checked.
`timescale 1ns / 1ps

module integer_array_table_engine_tb;
  import iate_pkg::*;

  localparam int TBL_DEPTH = 256;
  localparam int RANDOM_WORDS = 1000;
  // Worst command is a full sort of a reversed table.
  localparam longint CYCLE_LIMIT =
    longint'(RANDOM_WORDS + 400) * longint'(TBL_DEPTH * TBL_DEPTH) * 64'sd4;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  cmd_word_t cmd = '0;
  logic      cmd_valid = 1'b0;
  logic      cmd_stall;
  rsp_word_t rsp;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;

  integer_array_table_engine u_top (
    .clk(clk), .rst(rst),
    .cmd(cmd), .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .rsp(rsp), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the table, updated as each command word is accepted.
  logic signed [31:0] shadow_tbl [TBL_DEPTH];
  int unsigned        shadow_len;
  rsp_word_t          pending_rsp [$];
  int                 fail_count = 0;
  longint             cycle_count = 0;
  bit                 quiet_tail = 1'b0;
  bit                 hold_rsp = 1'b0;

  // Sort the shadow table ascending in place (insertion sort, stable).
  function automatic void shadow_sort();
    logic signed [31:0] v;
    int j;
    for (int k = 1; k < shadow_len; k++) begin
      v = shadow_tbl[k];
      j = k;
      while (j > 0 && shadow_tbl[j-1] > v) begin
        shadow_tbl[j] = shadow_tbl[j-1];
        j--;
      end
      shadow_tbl[j] = v;
    end
  endfunction

  function automatic int shadow_find(logic signed [31:0] v);
    for (int k = 0; k < shadow_len; k++)
      if (shadow_tbl[k] == v) return k;
    return -1;
  endfunction

  // Apply one command to the shadow table and return the response it should produce.
  function automatic rsp_word_t table_outcome(cmd_word_t c);
    rsp_word_t r;
    int f, lo, hi, mid;
    logic signed [39:0] acc;
    logic signed [31:0] t;
    r = '0;
    case (c.kind)
      K_APPEND: begin
        if (shadow_len >= TBL_DEPTH) r.status = ST_FULL;
        else shadow_tbl[shadow_len++] = c.operand_value;
      end
      K_INSERT: begin
        if (c.position >= shadow_len) r.status = ST_RANGE;
        else if (shadow_len >= TBL_DEPTH) r.status = ST_FULL;
        else begin
          for (int k = shadow_len; k > c.position; k--) shadow_tbl[k] = shadow_tbl[k-1];
          shadow_tbl[c.position] = c.operand_value;
          shadow_len++;
        end
      end
      K_DELETE: begin
        f = shadow_find(c.operand_value);
        if (f < 0) r.status = ST_MISSING;
        else begin
          r.found_index = f[7:0];
          for (int k = f; k + 1 < shadow_len; k++) shadow_tbl[k] = shadow_tbl[k+1];
          shadow_len--;
        end
      end
      K_LSEARCH: begin
        f = shadow_find(c.operand_value);
        if (f < 0) r.status = ST_MISSING;
        else r.found_index = f[7:0];
      end
      K_BSEARCH: begin
        shadow_sort();
        lo = 0;
        hi = int'(shadow_len) - 1;
        f = -1;
        while (lo <= hi) begin
          mid = (lo + hi) / 2;
          if (shadow_tbl[mid] == c.operand_value) begin
            f = mid;
            break;
          end
          if (shadow_tbl[mid] < c.operand_value) lo = mid + 1;
          else hi = mid - 1;
        end
        if (f < 0) r.status = ST_MISSING;
        else r.found_index = f[7:0];
      end
      K_MIN: begin
        acc = 40'sd2147483647;
        for (int k = 0; k < shadow_len; k++)
          if (shadow_tbl[k] < acc) acc = shadow_tbl[k];
        r.result_value = acc;
      end
      K_MAX: begin
        acc = -40'sd2147483647;
        for (int k = 0; k < shadow_len; k++)
          if (shadow_tbl[k] > acc) acc = shadow_tbl[k];
        r.result_value = acc;
      end
      K_SUM: begin
        acc = '0;
        for (int k = 0; k < shadow_len; k++) acc += shadow_tbl[k];
        r.result_value = acc;
      end
      K_SORT: shadow_sort();
      K_REVERSE: begin
        for (int k = 0; k < shadow_len / 2; k++) begin
          t = shadow_tbl[k];
          shadow_tbl[k] = shadow_tbl[shadow_len-1-k];
          shadow_tbl[shadow_len-1-k] = t;
        end
      end
      K_SORTED: begin
        r.sorted_flag = 1'b1;
        for (int k = 0; k + 1 < shadow_len; k++)
          if (shadow_tbl[k] > shadow_tbl[k+1]) begin
            r.sorted_flag = 1'b0;
            break;
          end
      end
      default: ;
    endcase
    r.length = shadow_len[8:0];
    return r;
  endfunction

  // Directed rows: command plus, where obvious, the response typed in by hand.
  typedef struct {
    cmd_word_t c;
    bit        has_fixed;
    rsp_word_t fixed;
  } dir_row_t;

  dir_row_t dir_rows [$];

  function automatic cmd_word_t mk(logic [3:0] k, logic [7:0] p, logic signed [31:0] v);
    cmd_word_t c;
    c.kind = k;
    c.position = p;
    c.operand_value = v;
    return c;
  endfunction

  function automatic rsp_word_t mkr(logic [1:0] s, logic [7:0] i, logic signed [39:0] rv,
                                    logic fl, logic [8:0] len);
    rsp_word_t r;
    r.status = s;
    r.found_index = i;
    r.result_value = rv;
    r.sorted_flag = fl;
    r.length = len;
    return r;
  endfunction

  task automatic add_row(cmd_word_t c);
    dir_row_t d;
    d.c = c;
    d.has_fixed = 1'b0;
    d.fixed = '0;
    dir_rows = {dir_rows, d};
  endtask

  task automatic add_fixed(cmd_word_t c, rsp_word_t r);
    dir_row_t d;
    d.c = c;
    d.has_fixed = 1'b1;
    d.fixed = r;
    dir_rows = {dir_rows, d};
  endtask

  initial begin
    // Empty table: min/max sentinels, misses, out-of-range insert.
    add_fixed(mk(K_MIN, 8'd0, 32'sd0), mkr(ST_OK, 8'd0, 40'sd2147483647, 1'b0, 9'd0));
    add_fixed(mk(K_MAX, 8'd0, 32'sd0), mkr(ST_OK, 8'd0, -40'sd2147483647, 1'b0, 9'd0));
    add_fixed(mk(K_SUM, 8'd0, 32'sd0), mkr(ST_OK, 8'd0, 40'sd0, 1'b0, 9'd0));
    add_fixed(mk(K_SORTED, 8'd0, 32'sd0), mkr(ST_OK, 8'd0, 40'sd0, 1'b1, 9'd0));
    add_fixed(mk(K_INSERT, 8'd0, 32'sd5), mkr(ST_RANGE, 8'd0, 40'sd0, 1'b0, 9'd0));
    add_fixed(mk(K_DELETE, 8'd0, 32'sd5), mkr(ST_MISSING, 8'd0, 40'sd0, 1'b0, 9'd0));
    add_fixed(mk(K_LSEARCH, 8'd0, 32'sd5), mkr(ST_MISSING, 8'd0, 40'sd0, 1'b0, 9'd0));
    add_fixed(mk(K_BSEARCH, 8'd0, 32'sd5), mkr(ST_MISSING, 8'd0, 40'sd0, 1'b0, 9'd0));
    // Extremes of the value range.
    add_fixed(mk(K_APPEND, 8'hFF, 32'h7FFF_FFFF), mkr(ST_OK, 8'd0, 40'sd0, 1'b0, 9'd1));
    add_fixed(mk(K_APPEND, 8'h00, 32'h8000_0000), mkr(ST_OK, 8'd0, 40'sd0, 1'b0, 9'd2));
    add_fixed(mk(K_MIN, 8'd0, 32'sd0), mkr(ST_OK, 8'd0, -40'sd2147483648, 1'b0, 9'd2));
    add_fixed(mk(K_MAX, 8'd0, 32'sd0), mkr(ST_OK, 8'd0, 40'sd2147483647, 1'b0, 9'd2));
    add_fixed(mk(K_SUM, 8'd0, 32'sd0), mkr(ST_OK, 8'd0, -40'sd1, 1'b0, 9'd2));
    add_fixed(mk(K_INSERT, 8'd2, 32'sd1), mkr(ST_RANGE, 8'd0, 40'sd0, 1'b0, 9'd2));
    add_row(mk(K_INSERT, 8'd1, -32'sd1));
    add_row(mk(K_INSERT, 8'd0, 32'sd0));
    add_row(mk(K_SORTED, 8'd0, 32'sd0));
    add_row(mk(K_LSEARCH, 8'd0, -32'sd1));
    add_row(mk(K_REVERSE, 8'd0, 32'sd0));
    add_row(mk(K_BSEARCH, 8'd0, 32'h8000_0000));
    add_row(mk(K_SORT, 8'd0, 32'sd0));
    add_row(mk(K_DELETE, 8'd0, 32'h7FFF_FFFF));
    add_row(mk(K_DELETE, 8'd0, 32'sd0));
    add_row(mk(4'd11, 8'hAA, 32'sd7));
    add_row(mk(4'd15, 8'h55, 32'sd7));
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Compare each accepted response word against the oldest expectation.
  always @(posedge clk) begin
    rsp_word_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected response word %p", rsp);
        fail_count++;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.status !== want.status) begin
          $error("status: expected %0d actual %0d", want.status, rsp.status);
          fail_count++;
        end
        if (rsp.found_index !== want.found_index) begin
          $error("found_index: expected %0d actual %0d", want.found_index, rsp.found_index);
          fail_count++;
        end
        if (rsp.result_value !== want.result_value) begin
          $error("result_value: expected %0d actual %0d", want.result_value, rsp.result_value);
          fail_count++;
        end
        if (rsp.sorted_flag !== want.sorted_flag) begin
          $error("sorted_flag: expected %0d actual %0d", want.sorted_flag, rsp.sorted_flag);
          fail_count++;
        end
        if (rsp.length !== want.length) begin
          $error("length: expected %0d actual %0d", want.length, rsp.length);
          fail_count++;
        end
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off, none in the quiet tail.
  initial begin
    int gap;
    @(negedge rst);
    while (1) begin
      @(posedge clk);
      if (hold_rsp) begin
        rsp_stall <= 1'b1;
        repeat (3000) @(posedge clk);
        hold_rsp = 1'b0;
        rsp_stall <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 11);
        rsp_stall <= 1'b1;
        repeat (gap) @(posedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  // Offer one command word; hold it until accepted, then record what it should return.
  task automatic send_word(cmd_word_t c, bit has_fixed, rsp_word_t fixed);
    rsp_word_t r;
    cmd <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
    r = table_outcome(c);
    if (has_fixed && r !== fixed) begin
      $error("directed row %p: expected %p, predictor %p", c, fixed, r);
      fail_count++;
    end
    if (has_fixed) r = fixed;
    pending_rsp = {pending_rsp, r};
  endtask

  // Random command with the value drawn half the time, when the table is not empty, from what is already in it.
  function automatic cmd_word_t rand_cmd(int unsigned n_item);
    cmd_word_t c;
    int w;
    c.position = (shadow_len > 0 && $urandom_range(0, 3) != 0) ?
                 8'($urandom_range(0, shadow_len - 1)) : 8'($urandom);
    if (shadow_len > 0 && $urandom_range(0, 1) == 1)
      c.operand_value = shadow_tbl[$urandom_range(0, shadow_len - 1)];
    else if ($urandom_range(0, 3) == 0)
      c.operand_value = $urandom;
    else
      c.operand_value = 32'($signed($urandom_range(0, 40)) - 20);
    w = $urandom_range(0, 99);
    // Grow the table hard during one stretch so the full case is reached.
    if (n_item >= 300 && n_item < 600) w = (w < 70) ? 0 : w;
    if (w < 25) c.kind = K_APPEND;
    else if (w < 40) c.kind = K_INSERT;
    else if (w < 52) c.kind = K_DELETE;
    else if (w < 60) c.kind = K_LSEARCH;
    else if (w < 66) c.kind = K_BSEARCH;
    else if (w < 72) c.kind = K_MIN;
    else if (w < 78) c.kind = K_MAX;
    else if (w < 84) c.kind = K_SUM;
    else if (w < 87) c.kind = K_SORT;
    else if (w < 92) c.kind = K_REVERSE;
    else if (w < 97) c.kind = K_SORTED;
    else c.kind = 4'($urandom_range(11, 15));
    return c;
  endfunction

  initial begin
    int gap;
    rsp_word_t none;
    none = '0;
    shadow_len = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) send_word(dir_rows[i].c, dir_rows[i].has_fixed, dir_rows[i].fixed);
    cmd_valid <= 1'b0;

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == 150) hold_rsp = 1'b1;
      if (n == RANDOM_WORDS - 100) quiet_tail = 1'b1;
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        // Drop valid for a burst of idle cycles.
        gap = $urandom_range(1, 11);
        cmd_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      send_word(rand_cmd(n), 1'b0, none);
    end
    // Fill to the brim and probe the full table.
    while (shadow_len < TBL_DEPTH) send_word(mk(K_APPEND, 8'd0, $urandom), 1'b0, none);
    send_word(mk(K_APPEND, 8'd0, 32'sd1), 1'b0, none);
    send_word(mk(K_INSERT, 8'd0, 32'sd1), 1'b0, none);
    send_word(mk(K_INSERT, 8'hFF, 32'sd1), 1'b0, none);
    send_word(mk(K_SUM, 8'd0, 32'sd0), 1'b0, none);
    send_word(mk(K_BSEARCH, 8'd0, shadow_tbl[17]), 1'b0, none);
    send_word(mk(K_SORTED, 8'd0, 32'sd0), 1'b0, none);
    cmd_valid <= 1'b0;

    // Drain: wait for every expected word, then allow a tail for stray output.
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/iate_pkg.sv
hw/rtl/iate_mem.sv
hw/rtl/integer_array_table_engine.sv
verif/integer_array_table_engine_tb.sv
